FILE: hw/rtl/aes_block_decrypt_modes_top_assert.svh
// assertion macros shared by the aes block decrypt modules
`ifndef AES_BLOCK_DECRYPT_MODES_TOP_ASSERT_SVH
`define AES_BLOCK_DECRYPT_MODES_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define AES_BDM_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aes_bdm check failed");

// next-cycle implication, sampled on clk, off during reset
`define AES_BDM_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aes_bdm check failed");

`endif

FILE: hw/rtl/aes_bdm_pkg.sv
// shared types, constants and round functions for the aes block decryptor
package aes_bdm_pkg;

    localparam int BLOCK_BITS   = 128;
    localparam int RK_ROWS      = 15;
    localparam int RK_ADDR_W    = $clog2(RK_ROWS);
    localparam int MAX_RK_WORDS = 60;
    localparam int WIDX_W       = $clog2(MAX_RK_WORDS);
    localparam int WIN_DEPTH    = 8;
    localparam int FIFO_DEPTH   = 2;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KLEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_A  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_B  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_C  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_D  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SV_HI  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SV_LO  = 3'd7;

    // mode and key length codes
    localparam logic [1:0] MODE_ECB  = 2'd0;
    localparam logic [1:0] MODE_CBC  = 2'd1;
    localparam logic [1:0] MODE_CFB1 = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam logic [1:0] KLEN_128  = 2'd0;
    localparam logic [1:0] KLEN_192  = 2'd1;

    typedef enum logic [1:0] {
        OP_ECB,
        OP_CBC,
        OP_CFB1
    } op_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_KEXP,
        BS_START,
        BS_DEC,
        BS_ENC,
        BS_OUT
    } back_state_t;

    typedef struct packed {
        op_t                   op;
        logic [BLOCK_BITS-1:0] block;
    } q_entry_t;

    typedef struct packed {
        logic [1:0]   mode;
        logic [1:0]   klen;
        logic [255:0] key;
        logic [127:0] sv;
    } cfg_t;

    typedef struct packed {
        logic reload_iv;
        logic key_change;
    } cfg_evt_t;

    localparam logic [2047:0] FWD_BOX = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [2047:0] INV_BOX = {
        128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] fwd_sub(input logic [7:0] b);
        return FWD_BOX[{~b, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] inv_sub(input logic [7:0] b);
        return INV_BOX[{~b, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {fwd_sub(w[31:24]), fwd_sub(w[23:16]), fwd_sub(w[15:8]), fwd_sub(w[7:0])};
    endfunction

    // number of rounds, codes two and three behave as 256-bit key
    function automatic logic [3:0] num_rounds(input logic [1:0] klen);
        logic [3:0] nr;
        unique case (klen)
            KLEN_128: nr = 4'd10;
            KLEN_192: nr = 4'd12;
            default:  nr = 4'd14;
        endcase
        return nr;
    endfunction

    function automatic logic [7:0] get_byte(input logic [127:0] s, input int idx);
        return s[127 - 8*idx -: 8];
    endfunction

    // forward round: sub bytes, shift rows, mix columns unless last, add key
    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic last);
        logic [7:0]   t [16];
        logic [7:0]   a0, a1, a2, a3, all;
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                t[j + 4*c] = fwd_sub(get_byte(s, j + 4*((c + j) & 3)));
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ all ^ xt(a0 ^ a1);
                t[4*c+1] = a1 ^ all ^ xt(a1 ^ a2);
                t[4*c+2] = a2 ^ all ^ xt(a2 ^ a3);
                t[4*c+3] = a3 ^ all ^ xt(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127 - 8*i -: 8] = t[i];
        end
        return r ^ rk;
    endfunction

    // inverse round: inv shift rows, inv sub bytes, add key, inv mix unless last
    function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic last);
        logic [7:0]   t [16];
        logic [7:0]   m [4][4];
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                t[j + 4*c] = inv_sub(get_byte(s, j + 4*((c + 4 - j) & 3))) ^
                             get_byte(rk, j + 4*c);
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                for (int j = 0; j < 4; j++) begin
                    m[j][0] = t[4*c+j];
                    m[j][1] = xt(m[j][0]);
                    m[j][2] = xt(m[j][1]);
                    m[j][3] = xt(m[j][2]);
                end
                // 14 = 8+4+2, 11 = 8+2+1, 13 = 8+4+1, 9 = 8+1
                t[4*c]   = (m[0][3]^m[0][2]^m[0][1]) ^ (m[1][3]^m[1][1]^m[1][0]) ^
                           (m[2][3]^m[2][2]^m[2][0]) ^ (m[3][3]^m[3][0]);
                t[4*c+1] = (m[0][3]^m[0][0]) ^ (m[1][3]^m[1][2]^m[1][1]) ^
                           (m[2][3]^m[2][1]^m[2][0]) ^ (m[3][3]^m[3][2]^m[3][0]);
                t[4*c+2] = (m[0][3]^m[0][2]^m[0][0]) ^ (m[1][3]^m[1][0]) ^
                           (m[2][3]^m[2][2]^m[2][1]) ^ (m[3][3]^m[3][1]^m[3][0]);
                t[4*c+3] = (m[0][3]^m[0][1]^m[0][0]) ^ (m[1][3]^m[1][2]^m[1][0]) ^
                           (m[2][3]^m[2][0]) ^ (m[3][3]^m[3][2]^m[3][1]);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127 - 8*i -: 8] = t[i];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/aes_block_decrypt_modes_top.sv
// top level of the aes block decryptor with ecb, cbc and cfb1 chaining
//
//  channel   handshake            payload                      width
//  ------    ---------            -------                      -----
//  input     in_valid / in_ready  cipher_hi, cipher_lo         2 x 64
//  output    out_valid/out_ready  plain_hi, plain_lo           2 x 64
//  config    cfg_we (no wait)     cfg_index, cfg_data          3 + 64
//
//  ecb and cbc run one aes round per cycle
//  cfb1 runs one full encryption per bit
//  after a key or key length write the first item first runs key expansion,
//  one schedule word per cycle
//  reset clears control state and the chaining vector; round keys are rebuilt on use
//  a two-item queue sits between input and the round engine, and the result
//  register lets a finished item wait while the next one is taken
module aes_block_decrypt_modes_top
    import aes_bdm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [63:0]           cipher_hi,
    input  logic [63:0]           cipher_lo,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [63:0]           plain_hi,
    output logic [63:0]           plain_lo,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg_reg, cfg_next;
    cfg_evt_t   evt_reg, evt_next;
    logic       q_full;
    logic       q_push;
    q_entry_t   q_push_entry;
    logic       q_pop;
    logic       q_valid;
    q_entry_t   q_head;

    // register file; every write reloads the chaining vector through evt_reg into cv_reg
    always_comb
    begin
        cfg_next            = cfg_reg;
        evt_next.reload_iv  = cfg_we;
        evt_next.key_change = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:  cfg_next.mode = cfg_data[1:0];
                REG_KLEN:
                begin
                    cfg_next.klen       = cfg_data[1:0];
                    evt_next.key_change = 1'b1;
                end
                REG_KEY_A:
                begin
                    cfg_next.key[255:192] = cfg_data;
                    evt_next.key_change   = 1'b1;
                end
                REG_KEY_B:
                begin
                    cfg_next.key[191:128] = cfg_data;
                    evt_next.key_change   = 1'b1;
                end
                REG_KEY_C:
                begin
                    cfg_next.key[127:64] = cfg_data;
                    evt_next.key_change  = 1'b1;
                end
                REG_KEY_D:
                begin
                    cfg_next.key[63:0]  = cfg_data;
                    evt_next.key_change = 1'b1;
                end
                REG_SV_HI: cfg_next.sv[127:64] = cfg_data;
                REG_SV_LO: cfg_next.sv[63:0]   = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
            evt_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            evt_reg <= evt_next;
        end
    end

    // front: takes items and tags the chaining mode
    aes_bdm_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cipher_hi (cipher_hi),
        .cipher_lo (cipher_lo),
        .mode      (cfg_reg.mode),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_push_entry)
    );

    // queue decouples acceptance from the round engine
    aes_bdm_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .q_valid    (q_valid),
        .q_entry    (q_head)
    );

    // back: key schedule, rounds, chaining, result register
    aes_bdm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .evt       (evt_reg),
        .q_valid   (q_valid),
        .q_entry   (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .plain_hi  (plain_hi),
        .plain_lo  (plain_lo)
    );

endmodule

FILE: hw/rtl/aes_bdm_fifo.sv
// two-entry item queue between front and back
module aes_bdm_fifo
    import aes_bdm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     full,
    input  logic     pop,
    output logic     q_valid,
    output q_entry_t q_entry
);

    q_entry_t                slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

`include "aes_block_decrypt_modes_top_assert.svh"

    `AES_BDM_CHECK(a_no_push_when_full, full, !push)
    `AES_BDM_CHECK(a_no_pop_when_empty, !q_valid, !pop)
    `AES_BDM_CHECK_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

FILE: hw/rtl/aes_bdm_front.sv
// input side: takes items, tags them with the chaining mode, drops meaningless modes
module aes_bdm_front
    import aes_bdm_pkg::*;
(
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [63:0]  cipher_hi,
    input  logic [63:0]  cipher_lo,
    input  logic [1:0]   mode,
    input  logic         q_full,
    output logic         q_push,
    output q_entry_t     q_entry
);

    logic keep;

    assign in_ready = !q_full;

    always_comb
    begin
        keep           = 1'b1;
        q_entry.block  = {cipher_hi, cipher_lo};
        q_entry.op     = OP_ECB;
        unique case (mode)
            MODE_ECB:  q_entry.op = OP_ECB;
            MODE_CBC:  q_entry.op = OP_CBC;
            MODE_CFB1: q_entry.op = OP_CFB1;
            MODE_NONE: keep = 1'b0;
        endcase
    end

    // mode three items are taken and yield nothing
    assign q_push = in_valid && in_ready && keep;

endmodule

FILE: hw/rtl/aes_bdm_back.sv
// execution side: key schedule, one aes round per cycle, chaining and result register
module aes_bdm_back
    import aes_bdm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  cfg_evt_t     evt,
    input  logic         q_valid,
    input  q_entry_t     q_entry,
    output logic         q_pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [63:0]  plain_hi,
    output logic [63:0]  plain_lo
);

    back_state_t             state_reg, state_next;
    op_t                     op_reg, op_next;
    logic [BLOCK_BITS-1:0]   ct_reg, ct_next;
    logic [BLOCK_BITS-1:0]   st_reg, st_next;
    logic [BLOCK_BITS-1:0]   cv_reg, cv_next;
    logic [BLOCK_BITS-1:0]   res_reg, res_next;
    logic [BLOCK_BITS-1:0]   out_data_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [3:0]              round_reg, round_next;
    logic [6:0]              bit_cnt_reg, bit_cnt_next;
    logic [WIDX_W-1:0]       widx_reg, widx_next;
    logic [2:0]              jdx_reg, jdx_next;
    logic [7:0]              rcon_reg, rcon_next;
    logic                    keys_ready_reg, keys_ready_next;
    logic [31:0]             win_reg [WIN_DEPTH];
    logic [BLOCK_BITS-1:0]   rk_mem [RK_ROWS];

    logic [3:0]              nr;
    logic [2:0]              nk_m1;
    logic [WIDX_W-1:0]       last_word;
    logic [RK_ADDR_W-1:0]    rk_addr;
    logic [BLOCK_BITS-1:0]   rk_row;
    logic [31:0]             key_word;
    logic [31:0]             tmp_word;
    logic [31:0]             new_word;
    logic                    rk_we;
    logic                    out_load;
    logic                    last_round;
    logic [BLOCK_BITS-1:0]   enc_out;
    logic [BLOCK_BITS-1:0]   dec_out;

    assign nr        = num_rounds(cfg.klen);
    assign last_word = {nr, 2'b11};
    assign rk_row    = rk_mem[rk_addr];
    assign key_word  = cfg.key[{~widx_reg[2:0], 5'b00000} +: 32];
    assign last_round = (round_reg == nr);
    assign enc_out   = enc_round(st_reg, rk_row, last_round);
    assign dec_out   = dec_round(st_reg, rk_row, last_round);

    always_comb
    begin
        unique case (cfg.klen)
            KLEN_128: nk_m1 = 3'd3;
            KLEN_192: nk_m1 = 3'd5;
            default:  nk_m1 = 3'd7;
        endcase
    end

    // next schedule word
    always_comb
    begin
        tmp_word = win_reg[0];
        if (jdx_reg == 3'd0)
        begin
            tmp_word = sub_word({win_reg[0][23:0], win_reg[0][31:24]}) ^ {rcon_reg, 24'h000000};
        end
        else if ((nk_m1 == 3'd7) && (jdx_reg == 3'd4))
        begin
            tmp_word = sub_word(win_reg[0]);
        end
        if (widx_reg <= {{(WIDX_W-3){1'b0}}, nk_m1})
        begin
            new_word = key_word;
        end
        else
        begin
            new_word = win_reg[nk_m1] ^ tmp_word;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        ct_next         = ct_reg;
        st_next         = st_reg;
        cv_next         = cv_reg;
        res_next        = res_reg;
        round_next      = round_reg;
        bit_cnt_next    = bit_cnt_reg;
        widx_next       = widx_reg;
        jdx_next        = jdx_reg;
        rcon_next       = rcon_reg;
        keys_ready_next = keys_ready_reg;
        q_pop           = 1'b0;
        rk_we           = 1'b0;
        rk_addr         = '0;
        out_load        = 1'b0;

        unique case (state_reg)
            BS_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    op_next      = q_entry.op;
                    ct_next      = q_entry.block;
                    res_next     = '0;
                    bit_cnt_next = '0;
                    if (!keys_ready_reg)
                    begin
                        widx_next  = '0;
                        jdx_next   = '0;
                        rcon_next  = 8'h01;
                        state_next = BS_KEXP;
                    end
                    else
                    begin
                        state_next = BS_START;
                    end
                end
            end
            BS_KEXP:
            begin
                rk_we     = 1'b1;
                widx_next = widx_reg + 1'b1;
                jdx_next  = (jdx_reg == nk_m1) ? 3'd0 : jdx_reg + 1'b1;
                if ((widx_reg > {{(WIDX_W-3){1'b0}}, nk_m1}) && (jdx_reg == 3'd0))
                begin
                    rcon_next = xt(rcon_reg);
                end
                if (widx_reg == last_word)
                begin
                    keys_ready_next = 1'b1;
                    state_next      = BS_START;
                end
            end
            BS_START:
            begin
                round_next = 4'd1;
                if (op_reg == OP_CFB1)
                begin
                    rk_addr    = '0;
                    st_next    = cv_reg ^ rk_row;
                    state_next = BS_ENC;
                end
                else
                begin
                    rk_addr    = nr;
                    st_next    = ct_reg ^ rk_row;
                    state_next = BS_DEC;
                end
            end
            BS_DEC:
            begin
                rk_addr    = nr - round_reg;
                st_next    = dec_out;
                round_next = round_reg + 1'b1;
                if (last_round)
                begin
                    if (op_reg == OP_CBC)
                    begin
                        res_next = dec_out ^ cv_reg;
                        cv_next  = ct_reg;
                    end
                    else
                    begin
                        res_next = dec_out;
                    end
                    state_next = BS_OUT;
                end
            end
            BS_ENC:
            begin
                rk_addr    = round_reg;
                st_next    = enc_out;
                round_next = round_reg + 1'b1;
                if (last_round)
                begin
                    // top keystream bit against the next ciphertext bit
                    res_next     = {res_reg[126:0], ct_reg[127] ^ enc_out[127]};
                    cv_next      = {cv_reg[126:0], ct_reg[127]};
                    ct_next      = {ct_reg[126:0], 1'b0};
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                    state_next   = (bit_cnt_reg == 7'd127) ? BS_OUT : BS_START;
                end
            end
            BS_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase

        if (evt.reload_iv)
        begin
            cv_next = cfg.sv;
        end
        if (evt.key_change)
        begin
            keys_ready_next = 1'b0;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BS_IDLE;
            keys_ready_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cv_reg         <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            keys_ready_reg <= keys_ready_next;
            out_valid_reg  <= out_valid_next;
            cv_reg         <= cv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        ct_reg      <= ct_next;
        st_reg      <= st_next;
        res_reg     <= res_next;
        round_reg   <= round_next;
        bit_cnt_reg <= bit_cnt_next;
        widx_reg    <= widx_next;
        jdx_reg     <= jdx_next;
        rcon_reg    <= rcon_next;
        if (out_load)
        begin
            out_data_reg <= res_reg;
        end
        if (rk_we)
        begin
            win_reg[0] <= new_word;
            for (int k = 1; k < WIN_DEPTH; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
            rk_mem[widx_reg[WIDX_W-1:2]][{~widx_reg[1:0], 5'b00000} +: 32] <= new_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign plain_hi  = out_data_reg[127:64];
    assign plain_lo  = out_data_reg[63:0];

`include "aes_block_decrypt_modes_top_assert.svh"

    `AES_BDM_CHECK_NEXT(a_pop_starts_work, q_pop, state_reg != BS_IDLE)
    `AES_BDM_CHECK_NEXT(a_out_loaded, (state_reg == BS_OUT) && (!out_valid_reg || out_ready),
        out_valid_reg)
    `AES_BDM_CHECK_NEXT(a_kexp_exit, state_reg == BS_KEXP,
        (state_reg == BS_KEXP) || (state_reg == BS_START))

endmodule
